@@ rtl/core/led_blink_pattern_sequencer_unit_defines.svh @@
// assertion helpers for the led blink pattern sequencer
`ifndef LED_BLINK_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LBPS_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("lbps: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define LBPS_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("lbps: next-cycle check failed");

`endif

@@ rtl/core/lbps_pkg.sv @@
`timescale 1ns / 1ps

package lbps_pkg;

	// field and register widths
	localparam int unsigned DUR_W           = 24;
	localparam int unsigned STEP_W          = 16;
	localparam int unsigned BCNT_W          = 8;
	localparam int unsigned ADD_W           = BCNT_W + 1;
	localparam int unsigned OUT_W           = 5;
	localparam int unsigned IDX_W           = 8;
	localparam int unsigned CFG_DATA_W      = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE = 8'd0;
	localparam logic [IDX_W-1:0] REG_DARK   = 8'd1;
	localparam logic [IDX_W-1:0] REG_LIT    = 8'd2;
	localparam logic [IDX_W-1:0] REG_STEP   = 8'd3;

	// register reset values
	localparam logic [DUR_W-1:0]  DARK_RST = 24'd500;
	localparam logic [DUR_W-1:0]  LIT_RST  = 24'd250;
	localparam logic [STEP_W-1:0] STEP_RST = 16'd100;

	// item opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_BLINK = 1'b1;

	typedef struct packed {
		logic              enable;
		logic [DUR_W-1:0]  dark_ms;
		logic [DUR_W-1:0]  lit_ms;
		logic [STEP_W-1:0] step_ms;
	} cfg_t;

	typedef struct packed {
		logic             dark;
		logic [DUR_W-1:0] dur;
	} seg_t;

	typedef struct packed {
		logic we;
		seg_t data;
	} seg_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_READ,
		ST_DONE
	} state_t;

	// remaining time minus step, saturating at zero
	function automatic logic [DUR_W-1:0] reduce_time(input logic [DUR_W-1:0] t,
		input logic [STEP_W-1:0] step);
		logic [DUR_W-1:0] step_x;
		step_x = {{(DUR_W-STEP_W){1'b0}}, step};
		return (t > step_x) ? t - step_x : '0;
	endfunction

endpackage

@@ rtl/core/led_blink_pattern_sequencer_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------------
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
// s       | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata blink_count
// m       | out       | m_tvalid/m_tready  | m_tdata led_pin, entries_added, queue_fill
//
// one item at a time: a tick passes IDLE and DONE before the next accept, and one that pops
// a segment also passes READ (registered read of the segment memory); a blink request passes
// PUSH, writing n segments, one per cycle through the memory write port (up to 16 at depth 16)
// reset clears pointers, fill, timers and drives the pin dark; memory contents are not cleared
// a held result in the output register does not block the next input transfer, only the
// following result load waits for m_tready

`include "led_blink_pattern_sequencer_unit_defines.svh"

module led_blink_pattern_sequencer_unit #(
	parameter int unsigned QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lbps_pkg::IDX_W-1:0]       cfg_index,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] blink_count
	input  logic                             s_tuser,  // [0] opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata   // [0] led_pin, [5:1] entries_added,
	                                                   // [10:6] queue_fill, [15:11] zero
);
	import lbps_pkg::*;

	localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

	cfg_t              cfg_q;
	seg_wr_t           mem_wr;
	seg_t              mem_rdata;
	logic [PTR_W-1:0]  mem_waddr, mem_raddr;
	logic              res_pin;
	logic [OUT_W-1:0]  res_added, res_fill;

	// configuration registers, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable  <= 1'b0;
			cfg_q.dark_ms <= DARK_RST;
			cfg_q.lit_ms  <= LIT_RST;
			cfg_q.step_ms <= STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE: cfg_q.enable  <= cfg_data[0];
				REG_DARK:   cfg_q.dark_ms <= cfg_data[DUR_W-1:0];
				REG_LIT:    cfg_q.lit_ms  <= cfg_data[DUR_W-1:0];
				REG_STEP:   cfg_q.step_ms <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lbps_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PTR_W       (PTR_W),
		.FILL_W      (FILL_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item_op    (s_tuser),
		.item_count (s_tdata[BCNT_W-1:0]),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_pin    (res_pin),
		.res_added  (res_added),
		.res_fill   (res_fill),
		.mem_wr     (mem_wr),
		.mem_waddr  (mem_waddr),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	lbps_seg_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (PTR_W)
	) u_seg_ram (
		.clk   (clk),
		.wr    (mem_wr),
		.waddr (mem_waddr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result packing
	assign m_tdata = {5'b0, res_fill, res_added, res_pin};

	// one item in flight: no accept right after an accept
	`LBPS_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a new result only follows a cycle of processing
	`LBPS_ASSERT_IMP(a_result_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))
	// nothing is enqueued while disabled
	`LBPS_ASSERT_IMP(a_disabled_no_add, clk, arst_n, m_tvalid && !cfg_q.enable,
		m_tdata[5:1] == 5'd0)

endmodule

@@ rtl/core/lbps_seg_ram.sv @@
`timescale 1ns / 1ps

module lbps_seg_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic               clk,
	input  lbps_pkg::seg_wr_t  wr,
	input  logic [AW-1:0]      waddr,
	input  logic [AW-1:0]      raddr,
	output lbps_pkg::seg_t     rdata
);
	import lbps_pkg::*;

	seg_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/lbps_ctrl.sv @@
`timescale 1ns / 1ps

module lbps_ctrl #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned PTR_W       = 4,
	parameter int unsigned FILL_W      = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbps_pkg::cfg_t               cfg,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         item_op,
	input  logic [lbps_pkg::BCNT_W-1:0]  item_count,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         res_pin,
	output logic [lbps_pkg::OUT_W-1:0]   res_added,
	output logic [lbps_pkg::OUT_W-1:0]   res_fill,
	output lbps_pkg::seg_wr_t            mem_wr,
	output logic [PTR_W-1:0]             mem_waddr,
	output logic [PTR_W-1:0]             mem_raddr,
	input  lbps_pkg::seg_t               mem_rdata
);
	import lbps_pkg::*;

	state_t state_q, state_d;

	logic [PTR_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] count_q;
	logic [DUR_W-1:0]  lit_q, dark_q;
	logic              pin_q;
	logic [ADD_W-1:0]  pushed_q, target_q;
	logic              out_valid_q;
	logic              out_pin_q;
	logic [OUT_W-1:0]  out_added_q, out_fill_q;

	logic accept, full, push_go, load_res, seg_dark;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// handshake and push qualifiers
	assign accept   = item_valid && item_ready;
	assign full     = (count_q == FILL_W'(QUEUE_DEPTH));
	assign push_go  = (state_q == ST_PUSH) && !full && (pushed_q != target_q);
	assign load_res = (state_q == ST_DONE) && (!out_valid_q || res_ready);
	// lead segment and every odd entry are dark, the rest lit
	assign seg_dark = (pushed_q == '0) || pushed_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!cfg.enable) begin
						state_d = ST_DONE;
					end else if (item_op == OP_BLINK) begin
						state_d = ST_PUSH;
					end else if ((lit_q != '0) || (dark_q != '0) || (count_q == '0)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_PUSH: begin
				if (!push_go) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready       = (state_q == ST_IDLE);
		mem_wr.we        = push_go;
		mem_wr.data.dark = seg_dark;
		mem_wr.data.dur  = seg_dark ? cfg.dark_ms : cfg.lit_ms;
		mem_waddr        = tail_q;
		mem_raddr        = head_q;
		res_valid        = out_valid_q;
		res_pin          = out_pin_q;
		res_added        = out_added_q;
		res_fill         = out_fill_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// queue pointers, timers and pin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			lit_q    <= '0;
			dark_q   <= '0;
			pin_q    <= 1'b1;
			pushed_q <= '0;
			target_q <= '0;
		end else begin
			if (accept) begin
				pushed_q <= '0;
				target_q <= {item_count, 1'b1};
				if (cfg.enable && (item_op == OP_TICK)) begin
					if (lit_q != '0) begin
						pin_q <= 1'b0;
						lit_q <= reduce_time(lit_q, cfg.step_ms);
					end else if (dark_q != '0) begin
						pin_q  <= 1'b1;
						dark_q <= reduce_time(dark_q, cfg.step_ms);
					end else if (count_q == '0) begin
						pin_q <= 1'b1;
					end
				end
			end
			// one segment per cycle into the queue
			if (push_go) begin
				tail_q   <= next_ptr(tail_q);
				count_q  <= count_q + 1'b1;
				pushed_q <= pushed_q + 1'b1;
			end
			// head segment read back, start it
			if (state_q == ST_READ) begin
				head_q  <= next_ptr(head_q);
				count_q <= count_q - 1'b1;
				if (mem_rdata.dark) begin
					dark_q <= mem_rdata.dur;
					pin_q  <= 1'b1;
				end else begin
					lit_q <= mem_rdata.dur;
					pin_q <= 1'b0;
				end
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_res) begin
			out_pin_q   <= pin_q;
			out_added_q <= OUT_W'(pushed_q);
			out_fill_q  <= OUT_W'(count_q);
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import lbps_pkg::*;

	// register indexes with nothing behind them
	localparam logic [IDX_W-1:0] REG_UNMAPPED     = 8'd4;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

	localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
	localparam int          QUIET_CYCLES = 40;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          HOLD_CYCLES  = 400;

	typedef struct packed {
		logic       op;
		logic [7:0] count;
	} led_item_t;

	typedef struct packed {
		logic       pin;
		logic [4:0] added;
		logic [4:0] fill;
	} led_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	led_blink_pattern_sequencer_unit #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// mirrored registers
	logic              seq_enable;
	logic [DUR_W-1:0]  seq_dark_ms;
	logic [DUR_W-1:0]  seq_lit_ms;
	logic [STEP_W-1:0] seq_step_ms;

	// mirrored segment fifo and timers
	seg_t        seg_fifo [DEPTH];
	int unsigned fifo_head;
	int unsigned fifo_tail;
	int unsigned fifo_fill;
	logic [25:0] lit_left;
	logic [25:0] dark_left;
	logic        pin_level;

	led_item_t   pending_items [$];
	led_result_t expected_leds [$];

	int  src_idle_pct = 0;
	int  sink_idle_pct = 0;
	int  hold_req = 0;
	int  hold_len = 0;
	int  fail_cnt = 0;
	int  stall_cycles = 0;
	logic s_fire = 1'b0;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [25:0] step_down(input logic [25:0] t);
		return (t > {10'd0, seq_step_ms}) ? t - {10'd0, seq_step_ms} : '0;
	endfunction

	function automatic logic push_seg(input seg_t seg);
		if (fifo_fill >= DEPTH)
			return 1'b0;
		seg_fifo[fifo_tail] = seg;
		fifo_tail = (fifo_tail + 1 >= DEPTH) ? 0 : fifo_tail + 1;
		fifo_fill++;
		return 1'b1;
	endfunction

	// expected pin, added count and fill after one item
	function automatic led_result_t predict_led(input logic op, input logic [7:0] count);
		led_result_t res;
		seg_t        dark_seg;
		seg_t        lit_seg;
		seg_t        seg;
		int unsigned added;
		added = 0;
		dark_seg = '{dark: 1'b1, dur: seq_dark_ms};
		lit_seg = '{dark: 1'b0, dur: seq_lit_ms};
		if (seq_enable) begin
			if (op == OP_BLINK) begin
				if (push_seg(dark_seg)) begin
					added = 1;
					for (int i = 0; i < count; i++) begin
						if (!push_seg(dark_seg))
							break;
						added++;
						if (!push_seg(lit_seg))
							break;
						added++;
					end
				end
			end else if (lit_left > 0) begin
				pin_level = 1'b0;
				lit_left = step_down(lit_left);
			end else if (dark_left > 0) begin
				pin_level = 1'b1;
				dark_left = step_down(dark_left);
			end else if (fifo_fill > 0) begin
				seg = seg_fifo[fifo_head];
				fifo_head = (fifo_head + 1 >= DEPTH) ? 0 : fifo_head + 1;
				fifo_fill--;
				if (seg.dark) begin
					dark_left = {2'b00, seg.dur};
					pin_level = 1'b1;
				end else begin
					lit_left = {2'b00, seg.dur};
					pin_level = 1'b0;
				end
			end else begin
				pin_level = 1'b1;
			end
		end
		res.pin = pin_level;
		res.added = added[4:0];
		res.fill = fifo_fill[4:0];
		return res;
	endfunction

	// sender: next item after a transfer or an idle slot
	always @(negedge clk) begin
		led_item_t item;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= item.op;
				s_tdata <= item.count;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random backpressure plus requested long hold-offs
	int hold_ack = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// monitor: check results, predict accepted items
	always @(posedge clk) begin
		led_result_t want;
		led_result_t got;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.pin = m_tdata[0];
				got.added = m_tdata[5:1];
				got.fill = m_tdata[10:6];
				if (expected_leds.size() == 0) begin
					$error("result with nothing expected: tdata %h", m_tdata);
					fail_cnt++;
				end else begin
					want = expected_leds.pop_front();
					if (got.pin !== want.pin) begin
						$error("led_pin: expected %0d, got %0d", want.pin, got.pin);
						fail_cnt++;
					end
					if (got.added !== want.added) begin
						$error("entries_added: expected %0d, got %0d", want.added, got.added);
						fail_cnt++;
					end
					if (got.fill !== want.fill) begin
						$error("queue_fill: expected %0d, got %0d", want.fill, got.fill);
						fail_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_leds.push_back(predict_led(s_tuser, s_tdata));
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("led_blink_pattern_sequencer_unit regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE: seq_enable = data[0];
			REG_DARK:   seq_dark_ms = data[DUR_W-1:0];
			REG_LIT:    seq_lit_ms = data[DUR_W-1:0];
			REG_STEP:   seq_step_ms = data[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// timing registers, upper bits of the write data randomized
	task automatic write_timing(input logic [DUR_W-1:0] dark, input logic [DUR_W-1:0] lit,
		input logic [STEP_W-1:0] step);
		write_reg(REG_DARK, {8'($urandom), dark});
		write_reg(REG_LIT, {8'($urandom), lit});
		write_reg(REG_STEP, {16'($urandom), step});
	endtask

	task automatic add_item(input logic op, input logic [7:0] count);
		pending_items.push_back('{op: op, count: count});
	endtask

	// waits until every item is sent, every result is back and the block has settled
	task automatic wait_for_quiet();
		while (pending_items.size() != 0 || s_tvalid || expected_leds.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic led_item_t random_item();
		led_item_t item;
		int r;
		r = $urandom_range(99);
		item.count = 8'($urandom);
		if (r < 64) begin
			item.op = OP_TICK;
		end else begin
			item.op = OP_BLINK;
			if (r < 88)
				item.count = 8'($urandom_range(3));
			else if (r < 97)
				item.count = 8'($urandom_range(15));
		end
		return item;
	endfunction

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++)
			pending_items.push_back(random_item());
	endtask

	initial begin
		seq_enable = 1'b0;
		seq_dark_ms = DARK_RST;
		seq_lit_ms = LIT_RST;
		seq_step_ms = STEP_RST;
		fifo_head = 0;
		fifo_tail = 0;
		fifo_fill = 0;
		lit_left = '0;
		dark_left = '0;
		pin_level = 1'b1;
		src_idle_pct = 16;
		sink_idle_pct = 85;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (QUIET_CYCLES) @(posedge clk);

		// disabled after reset: nothing changes
		add_item(OP_BLINK, 8'd3);
		add_item(OP_TICK, 8'd0);
		wait_for_quiet();

		write_reg(REG_ENABLE, 32'h8000_0001);
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_TOP, 32'h0000_0000);

		// default timing: empty tick, lead only, fill to full, request on full fifo
		add_item(OP_TICK, 8'hFF);
		add_item(OP_BLINK, 8'd0);
		add_item(OP_TICK, 8'd0);
		add_item(OP_TICK, 8'd0);
		add_item(OP_TICK, 8'd0);
		add_item(OP_BLINK, 8'd255);
		add_item(OP_BLINK, 8'd2);
		add_item(OP_TICK, 8'd0);
		add_item(OP_TICK, 8'd0);
		add_item(OP_TICK, 8'd0);
		wait_for_quiet();

		// zero-duration segments last one tick each
		write_timing(24'd0, 24'd0, 16'd1);
		add_item(OP_BLINK, 8'd2);
		repeat (5) add_item(OP_TICK, 8'd0);
		wait_for_quiet();

		// zero step: current segment never runs out
		write_timing(24'd7, 24'd7, 16'd0);
		add_item(OP_BLINK, 8'd1);
		repeat (3) add_item(OP_TICK, 8'd0);
		wait_for_quiet();

		// widest durations and step
		write_timing(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		add_item(OP_BLINK, 8'd1);
		repeat (2) add_item(OP_TICK, 8'd0);
		wait_for_quiet();

		// random phases
		for (int k = 0; k < 8; k++) begin
			if (k < 3) begin
				src_idle_pct = 16;
				sink_idle_pct = 85;
			end else if (k < 6) begin
				src_idle_pct = 85;
				sink_idle_pct = 16;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			case (k)
				0: begin
					write_timing(24'($urandom_range(600)), 24'($urandom_range(600)),
						16'($urandom_range(200, 1)));
					add_random(200);
				end
				1: begin
					write_timing(24'd0, 24'd0, 16'($urandom_range(3, 1)));
					add_random(200);
				end
				2: begin
					write_timing(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
					add_random(120);
				end
				3: begin
					// disabled stretch, then back on with state kept
					write_reg(REG_ENABLE, {31'($urandom), 1'b0});
					add_random(60);
					wait_for_quiet();
					write_reg(REG_ENABLE, {31'($urandom), 1'b1});
					write_timing(24'($urandom_range(300)), 24'($urandom_range(300)),
						16'($urandom_range(400, 50)));
					add_random(200);
				end
				4: begin
					write_timing(24'($urandom), 24'($urandom), 16'($urandom_range(16'hFFFF, 1)));
					add_random(150);
				end
				5: begin
					write_timing(24'($urandom_range(3)), 24'($urandom_range(3)), 16'd1);
					add_random(200);
				end
				6: begin
					// receiver holds off while the sender keeps offering
					write_timing(DARK_RST, LIT_RST, STEP_RST);
					hold_len = HOLD_CYCLES;
					hold_req++;
					add_random(250);
				end
				default: begin
					write_timing(24'($urandom_range(400)), 24'($urandom_range(400)),
						16'($urandom_range(150, 1)));
					add_random(180);
				end
			endcase
			wait_for_quiet();
		end

		if (fail_cnt == 0 && expected_leds.size() == 0) begin
			$display("led_blink_pattern_sequencer_unit regression: pass");
		end else begin
			$display("led_blink_pattern_sequencer_unit regression: fail");
		end
		$finish;
	end

endmodule
